// ===== hw/rtl/sat_pkg.sv =====
// Shared types and constants for the alarm slot table.
package sat_pkg;

	// Table size and the stored id, delay and data widths
	localparam int ALARM_SLOTS = 8;
	localparam int ID_WIDTH    = 8;
	localparam int DELAY_W     = 31;
	localparam int DATA_W      = 32;

	typedef logic [ID_WIDTH-1:0] id_t;
	typedef logic [DELAY_W-1:0]  delay_t;
	typedef logic [DATA_W-1:0]   data_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_COMMIT,
		ST_FLUSH
	} state_t;

	// Token handed from cell to cell during a walk
	typedef struct packed {
		logic vld;
		logic hit;   // an earlier cell holds the requested id
		logic free;  // an earlier cell is inactive
	} tok_t;

	// Request held for the whole item, seen by every cell
	typedef struct packed {
		logic   tick;
		id_t    id;
		logic   periodic;
		delay_t delay;
		logic   active;
		data_t  aux;
	} req_t;

	// Slot write command broadcast after an activate walk
	typedef struct packed {
		logic wr;
		logic use_match;
	} cmd_t;

	// Fire report from a cell
	typedef struct packed {
		logic  fire;
		id_t   id;
		data_t data;
	} fire_t;

endpackage

// ===== hw/rtl/sat_cell.sv =====
// One alarm slot: stored state, walk token stage and tick/compare logic.
module sat_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  sat_pkg::tok_t tok_in,
	input  sat_pkg::req_t req,
	input  sat_pkg::cmd_t cmd,
	output sat_pkg::tok_t tok_out,
	output sat_pkg::fire_t fire
);

	sat_pkg::tok_t   tok_q;
	logic            active_q;
	logic            periodic_q;
	sat_pkg::id_t    event_q;
	sat_pkg::delay_t delay_q;
	sat_pkg::delay_t count_q;
	sat_pkg::data_t  payload_q;
	logic            first_match_q;
	logic            first_free_q;

	logic            match;
	logic            hit_now;
	logic            sel_wr;
	sat_pkg::delay_t cnt_inc;

	// Compare and count
	assign match   = (event_q == req.id);
	assign cnt_inc = count_q + sat_pkg::delay_t'(1);
	assign hit_now = tok_q.vld && req.tick && active_q && (cnt_inc >= delay_q);
	assign sel_wr  = cmd.wr && (cmd.use_match ? first_match_q : first_free_q);

	// Pass token on, folding in this slot
	assign tok_out = '{vld: tok_q.vld, hit: tok_q.hit | match, free: tok_q.free | ~active_q};
	assign fire    = '{fire: hit_now, id: event_q, data: payload_q};

	// Slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q         <= '0;
			active_q      <= 1'b0;
			periodic_q    <= 1'b0;
			event_q       <= '0;
			delay_q       <= '0;
			count_q       <= '0;
			payload_q     <= '0;
			first_match_q <= 1'b0;
			first_free_q  <= 1'b0;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
				if (tok_q.vld && !req.tick) begin
					first_match_q <= match && !tok_q.hit;
					first_free_q  <= !active_q && !tok_q.free;
				end else if (tok_q.vld && active_q) begin
					// periodic alarm restarts, one-shot alarm is freed
					count_q <= (hit_now && periodic_q) ? '0 : cnt_inc;
					if (hit_now && !periodic_q) active_q <= 1'b0;
				end
			end
			if (sel_wr) begin
				event_q    <= req.id;
				active_q   <= req.active;
				delay_q    <= req.delay;
				periodic_q <= req.periodic;
				payload_q  <= req.aux;
				count_q    <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/sat_chain.sv =====
// Row of slot cells with the token chain and the fire report merge.
module sat_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  sat_pkg::tok_t  tok_head,
	input  sat_pkg::req_t  req,
	input  sat_pkg::cmd_t  cmd,
	output sat_pkg::tok_t  tok_tail,
	output sat_pkg::fire_t fire
);

	sat_pkg::tok_t  tok_link [sat_pkg::ALARM_SLOTS+1];
	sat_pkg::fire_t cell_fire [sat_pkg::ALARM_SLOTS];

	assign tok_link[0] = tok_head;
	assign tok_tail    = tok_link[sat_pkg::ALARM_SLOTS];

	for (genvar i = 0; i < sat_pkg::ALARM_SLOTS; i++) begin : g_cell
		sat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok_link[i]),
			.req     (req),
			.cmd     (cmd),
			.tok_out (tok_link[i+1]),
			.fire    (cell_fire[i])
		);
	end

	// Only the cell holding the token can fire; merge by OR
	always_comb begin
		fire = '0;
		for (int i = 0; i < sat_pkg::ALARM_SLOTS; i++) begin
			if (cell_fire[i].fire) begin
				fire.fire = 1'b1;
				fire.id   = fire.id | cell_fire[i].id;
				fire.data = fire.data | cell_fire[i].data;
			end
		end
	end

endmodule

// ===== hw/rtl/software_alarm_table.sv =====
// Top level of the alarm slot table: controller, result staging and output register.
//
// An input word is taken only when the table is idle. Each word sends one token
// down the row of eight slot cells, one cell per cycle unless the walk is
// paused. An activate word walks the cells and ends in a commit step that
// writes the chosen slot or gives the overflow word. A tick word walks the
// cells, then a final step releases the last fired word. The walk pauses for
// as long as a fired word must go out while the output register is still
// held by the downstream side, and the overflow word and the last fired word
// likewise wait for the output register. Results of a tick come out in slot
// order with tlast on the final one; a tick that fires nothing gives none.
module software_alarm_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // event_id[7:0], delay_word[39:8], aux_data[71:40]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // fired_id[7:0], fired_data[39:8]
	output logic        m_tuser,   // is_overflow
	output logic        m_tlast
);

	sat_pkg::state_t state_q, state_nxt;
	sat_pkg::req_t   req_q;
	sat_pkg::tok_t   tok_head, tok_tail;
	sat_pkg::cmd_t   cmd;
	sat_pkg::fire_t  fire;

	logic           accept;
	logic           adv;
	logic           out_free;
	logic           end_hit_q, end_free_q;
	logic           pend_vld_q;
	sat_pkg::id_t   pend_id_q;
	sat_pkg::data_t pend_data_q;

	logic           push;
	logic           push_ovf;
	logic           push_last;
	logic           pend_load;
	logic           pend_clr;

	logic           out_vld_q;
	logic [7:0]     out_id_q;
	sat_pkg::data_t out_data_q;
	logic           out_ovf_q;
	logic           out_last_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign tok_head = '{vld: accept, hit: 1'b0, free: 1'b0};

	sat_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.tok_head (tok_head),
		.req      (req_q),
		.cmd      (cmd),
		.tok_tail (tok_tail),
		.fire     (fire)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sat_pkg::ST_IDLE:   if (accept) state_nxt = sat_pkg::ST_WALK;
			sat_pkg::ST_WALK: begin
				if (adv && tok_tail.vld)
					state_nxt = req_q.tick ? sat_pkg::ST_FLUSH : sat_pkg::ST_COMMIT;
			end
			sat_pkg::ST_COMMIT: begin
				if (end_hit_q || end_free_q || out_free) state_nxt = sat_pkg::ST_IDLE;
			end
			sat_pkg::ST_FLUSH: begin
				if (!pend_vld_q || out_free) state_nxt = sat_pkg::ST_IDLE;
			end
			default:            state_nxt = sat_pkg::ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		s_tready  = 1'b0;
		adv       = 1'b1;
		cmd       = '0;
		push      = 1'b0;
		push_ovf  = 1'b0;
		push_last = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		case (state_q)
			sat_pkg::ST_IDLE:   s_tready = 1'b1;
			sat_pkg::ST_WALK: begin
				if (fire.fire && pend_vld_q && !out_free) adv = 1'b0;
				if (adv && fire.fire) begin
					pend_load = 1'b1;
					push      = pend_vld_q;
				end
			end
			sat_pkg::ST_COMMIT: begin
				if (end_hit_q || end_free_q) begin
					cmd.wr        = 1'b1;
					cmd.use_match = end_hit_q;
				end else if (out_free) begin
					push      = 1'b1;
					push_ovf  = 1'b1;
					push_last = 1'b1;
				end
			end
			sat_pkg::ST_FLUSH: begin
				if (pend_vld_q && out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					pend_clr  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sat_pkg::ST_IDLE;
			end_hit_q  <= 1'b0;
			end_free_q <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == sat_pkg::ST_WALK && adv && tok_tail.vld) begin
				end_hit_q  <= tok_tail.hit;
				end_free_q <= tok_tail.free;
			end
			if (pend_load)     pend_vld_q <= 1'b1;
			else if (pend_clr) pend_vld_q <= 1'b0;
			if (push)          out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.tick     <= s_tuser;
			req_q.id       <= sat_pkg::id_t'(s_tdata[7:0]);
			req_q.delay    <= s_tdata[38:8];
			req_q.periodic <= s_tdata[39];
			req_q.active   <= (s_tdata[39:8] != 32'd0);
			req_q.aux      <= s_tdata[71:40];
		end
		if (pend_load) begin
			pend_id_q   <= fire.id;
			pend_data_q <= fire.data;
		end
		if (push) begin
			out_id_q   <= push_ovf ? 8'd0 : 8'(pend_id_q);
			out_data_q <= push_ovf ? '0 : pend_data_q;
			out_ovf_q  <= push_ovf;
			out_last_q <= push_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_data_q, out_id_q};
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

	// The walk only pauses in the walk state (in the design only a tick walk can stall)
	a_stall_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> state_q == sat_pkg::ST_WALK)
		else $error("walk stalled outside a walk");

	// An overflow word is always the only and final word of its item
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("overflow word without tlast");

	// No staged fire word survives into the next item
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_vld_q)
		else $error("staged word left at idle");

	// A write command happens only after an activate walk
	a_cmd_activate: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !req_q.tick && state_q == sat_pkg::ST_COMMIT)
		else $error("slot write outside activate commit");

endmodule

// ===== tb/software_alarm_table_test.sv =====
// Self-checking stream testbench for the alarm slot table, with its own slot predictor.
module software_alarm_table_test;

	localparam logic KIND_ACTIVATE = 1'b0;
	localparam logic KIND_TICK     = 1'b1;
	localparam int   NUM_RANDOM    = 480;
	localparam int   DRAIN_CYCLES  = 40;
	localparam int   NUM_DIRECTED  = 22;

	// One result word as seen on the master side
	typedef struct packed {
		sat_pkg::id_t   id;
		sat_pkg::data_t data;
		logic           ovf;
		logic           last;
	} alarm_out_t;

	// One stimulus row; typed rows carry their expected outcome
	typedef struct packed {
		logic           kind;
		sat_pkg::id_t   id;
		logic [31:0]    delay_word;
		sat_pkg::data_t aux;
		logic           typed;   // expectation given in the row
		logic           t_fire;  // typed row expects one word
		sat_pkg::id_t   t_id;
		sat_pkg::data_t t_data;
		logic           t_ovf;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // event_id[7:0], delay_word[39:8], aux_data[71:40]
	logic        s_tuser = 1'b0; // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // fired_id[7:0], fired_data[39:8]
	logic        m_tuser;        // is_overflow
	logic        m_tlast;

	// Predictor copy of the slot table
	logic            slot_on     [sat_pkg::ALARM_SLOTS];
	sat_pkg::id_t    slot_id     [sat_pkg::ALARM_SLOTS];
	sat_pkg::delay_t slot_limit  [sat_pkg::ALARM_SLOTS];
	sat_pkg::data_t  slot_aux    [sat_pkg::ALARM_SLOTS];
	logic            slot_repeat [sat_pkg::ALARM_SLOTS];
	sat_pkg::delay_t slot_ticks  [sat_pkg::ALARM_SLOTS];

	alarm_out_t fresh_fires[$];    // words caused by the latest input word
	alarm_out_t awaited_fires[$];  // words still due on the master side
	stim_row_t  directed_rows[NUM_DIRECTED];

	int src_idle;
	int dst_idle;
	int errors = 0;

	software_alarm_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Compute the words caused by one input word and advance the slot copy
	function automatic void predict_alarms(input logic kind, input sat_pkg::id_t id,
			input logic [31:0] word, input sat_pkg::data_t aux);
		int pick;
		alarm_out_t res;
		fresh_fires.delete();
		pick = -1;
		if (kind == KIND_ACTIVATE) begin
			// matching id first, stale ids of free slots included
			for (int i = 0; i < sat_pkg::ALARM_SLOTS; i++) begin
				if (slot_id[i] == id) begin
					pick = i;
					break;
				end
			end
			if (pick < 0) begin
				for (int i = 0; i < sat_pkg::ALARM_SLOTS; i++) begin
					if (!slot_on[i]) begin
						pick = i;
						break;
					end
				end
			end
			if (pick < 0) begin
				res = '{'0, '0, 1'b1, 1'b1};
				fresh_fires.push_back(res);
			end else begin
				slot_id[pick]     = id;
				slot_on[pick]     = (word != 32'h0);
				slot_limit[pick]  = word[30:0];
				slot_aux[pick]    = aux;
				slot_repeat[pick] = word[31];
				slot_ticks[pick]  = '0;
			end
		end else begin
			// tick: advance active slots, fire in slot order
			for (int i = 0; i < sat_pkg::ALARM_SLOTS; i++) begin
				if (slot_on[i]) begin
					slot_ticks[i] = slot_ticks[i] + sat_pkg::delay_t'(1);
					if (slot_ticks[i] >= slot_limit[i]) begin
						res = '{slot_id[i], slot_aux[i], 1'b0, 1'b0};
						fresh_fires.push_back(res);
						if (slot_repeat[i])
							slot_ticks[i] = '0;
						else
							slot_on[i] = 1'b0;
					end
				end
			end
			if (fresh_fires.size() > 0)
				fresh_fires[fresh_fires.size() - 1].last = 1'b1;
		end
	endfunction

	// Offer one word, wait for the handshake, queue what it must cause
	task automatic apply_word(input stim_row_t row);
		alarm_out_t res;
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= row.kind;
		s_tdata  <= {row.aux, row.delay_word, row.id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_alarms(row.kind, row.id, row.delay_word, row.aux);
		if (row.typed) begin
			fresh_fires.delete();
			if (row.t_fire) begin
				res = '{row.t_id, row.t_data, row.t_ovf, 1'b1};
				fresh_fires.push_back(res);
			end
		end
		foreach (fresh_fires[i]) awaited_fires.push_back(fresh_fires[i]);
	endtask

	// Result checker and downstream ready
	always @(posedge clk) begin
		alarm_out_t got;
		alarm_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[7:0], m_tdata[39:8], m_tuser, m_tlast};
				if (awaited_fires.size() == 0) begin
					$display("%0t unexpected word: expected none, got id %h data %h ovf %b last %b",
						$time, got.id, got.data, got.ovf, got.last);
					errors++;
				end else begin
					want = awaited_fires.pop_front();
					if (got.id != want.id) begin
						$display("%0t fired_id: expected %h, got %h", $time, want.id, got.id);
						errors++;
					end
					if (got.data != want.data) begin
						$display("%0t fired_data: expected %h, got %h", $time, want.data, got.data);
						errors++;
					end
					if (got.ovf != want.ovf) begin
						$display("%0t is_overflow: expected %b, got %b", $time, want.ovf, got.ovf);
						errors++;
					end
					if (got.last != want.last) begin
						$display("%0t last: expected %b, got %b", $time, want.last, got.last);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= dst_idle);
		end
	end

	// Stimulus
	initial begin
		stim_row_t row;
		src_idle = 21;
		dst_idle = 54;
		foreach (slot_on[i]) begin
			slot_on[i]     = 1'b0;
			slot_id[i]     = '0;
			slot_limit[i]  = '0;
			slot_aux[i]    = '0;
			slot_repeat[i] = 1'b0;
			slot_ticks[i]  = '0;
		end
		directed_rows = '{
			// tick on an empty table
			'{KIND_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0},
			// cancel of an absent id 0 lands on a stale id 0 slot
			'{KIND_ACTIVATE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h11, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_TICK,     8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h11,
				32'hFFFF_FFFF, 1'b0},
			// periodic with zero delay fires on every tick
			'{KIND_ACTIVATE, 8'hFF, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			// fill the rest of the table, delay extremes included
			'{KIND_ACTIVATE, 8'h01, 32'h0000_0002, 32'h0000_0001, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h02, 32'h8000_0001, 32'h0000_0002, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h03, 32'h7FFF_FFFF, 32'h0000_0003, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h04, 32'hFFFF_FFFF, 32'h0000_0004, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h05, 32'h0000_0003, 32'h0000_0005, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h06, 32'h8000_0002, 32'h0000_0006, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h07, 32'h0000_0001, 32'h0000_0007, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			// full table: activate and cancel both overflow
			'{KIND_ACTIVATE, 8'h55, 32'h0000_0004, 32'h0000_0055, 1'b1, 1'b1, 8'h00, 32'h0, 1'b1},
			'{KIND_ACTIVATE, 8'h56, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 8'h00, 32'h0, 1'b1},
			'{KIND_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			// cancel an active alarm, then reuse its slot
			'{KIND_ACTIVATE, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_ACTIVATE, 8'h55, 32'h0000_0004, 32'h1234_5678, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			// rearm an existing id, count restarts
			'{KIND_ACTIVATE, 8'h01, 32'h0000_0001, 32'hDEAD_BEEF, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0},
			'{KIND_TICK,     8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 32'h0, 1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) apply_word(directed_rows[i]);

		// random words: mostly a small id pool with short delays so alarms fire
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM / 3) begin
				src_idle = 54;
				dst_idle = 21;
			end
			if (n == 2 * NUM_RANDOM / 3) begin
				src_idle = 0;
				dst_idle = 0;
			end
			row = '0;
			row.kind = ($urandom_range(0, 99) < 45) ? KIND_TICK : KIND_ACTIVATE;
			row.id = ($urandom_range(0, 99) < 80) ? sat_pkg::id_t'($urandom_range(0, 11))
				: sat_pkg::id_t'($urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0: row.delay_word = 32'h0;
				1: row.delay_word = $urandom;
				default: row.delay_word = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 6))};
			endcase
			row.aux = $urandom;
			apply_word(row);
		end
		s_tvalid <= 1'b0;

		while (awaited_fires.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS software_alarm_table");
		else
			$display("FAIL software_alarm_table");
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("FAIL software_alarm_table");
		$finish;
	end

endmodule
